// File: rtl/s2dd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package s2dd_pkg;

  // result queue sizing
  localparam int unsigned QUEUE_DEPTH_LOG2 = 3;
  localparam int unsigned MAX_RESULTS      = 4;
  localparam int unsigned VALUE_W          = 40;

  // descriptor parse phases, one-hot
  typedef enum logic [17:0] {
    PH_SYSID    = 18'h00001,
    PH_MODE     = 18'h00002,
    PH_BOND     = 18'h00004,
    PH_PROF     = 18'h00008,
    PH_SAT      = 18'h00010,
    PH_FREQ     = 18'h00020,
    PH_SYMR     = 18'h00040,
    PH_ISI      = 18'h00080,
    PH_SCR      = 18'h00100,
    PH_TSLICE   = 18'h00200,
    PH_NBOND    = 18'h00400,
    PH_SECID    = 18'h00800,
    PH_SOSF     = 18'h01000,
    PH_REFIDX   = 18'h02000,
    PH_PAYIDX   = 18'h04000,
    PH_BHID     = 18'h08000,
    PH_PILOT    = 18'h10000,
    PH_RESERVED = 18'h20000
  } phase_e;

  typedef enum logic [4:0] {
    FC_SYSTEM_ID     = 5'd0,
    FC_MODE          = 5'd1,
    FC_MULTI_STREAM  = 5'd2,
    FC_ROLL_OFF      = 5'd3,
    FC_NCR_VERSION   = 5'd4,
    FC_CHANNEL_BOND  = 5'd5,
    FC_POLARIZATION  = 5'd6,
    FC_TS_GS_MODE    = 5'd7,
    FC_RX_PROFILES   = 5'd8,
    FC_SATELLITE_ID  = 5'd9,
    FC_FREQUENCY     = 5'd10,
    FC_SYMBOL_RATE   = 5'd11,
    FC_INPUT_STREAM  = 5'd12,
    FC_SCRAMBLE_IDX  = 5'd13,
    FC_TIMESLICE     = 5'd14,
    FC_BONDS_MINUS1  = 5'd15,
    FC_SECONDARY_ID  = 5'd16,
    FC_SOSF_WH       = 5'd17,
    FC_REF_SCR_IDX   = 5'd18,
    FC_SFFI          = 5'd19,
    FC_PAY_SCR_IDX   = 5'd20,
    FC_HOP_PLAN_ID   = 5'd21,
    FC_PILOTS_WH     = 5'd22,
    FC_RESERVED_BYTE = 5'd23,
    FC_END           = 5'd24,
    FC_TRUNCATED     = 5'd25
  } field_e;

  typedef struct packed {
    field_e             code;
    logic [VALUE_W-1:0] value;
    logic               eor;
  } result_t;

  // bytes per field of each phase
  function automatic logic [2:0] phase_len(input phase_e ph);
    logic [2:0] len;
    unique case (ph)
      PH_SYSID, PH_FREQ, PH_SYMR, PH_SECID, PH_BHID: len = 3'd4;
      PH_SAT, PH_SCR, PH_REFIDX, PH_PAYIDX:          len = 3'd3;
      default:                                       len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/s2xv2_delivery_descriptor_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------------
// byte in   | input     | in_valid_i / in_ready_o   | data_byte_i, last_byte_i
// result    | output    | out_valid_o / out_ready_i | field_code_o, field_value_o, end_of_run_o
//
// each accepted byte is decoded in the cycle of its transfer; its 0..4 results enter the
// result queue at that edge, from which the output presents them in order
// a byte is taken whenever the queue has room for four results, so while it has room bytes
// flow at one per cycle; the single output port drains at most one result per cycle, which
// bounds the sustained rate where mode and bond bytes give three results each
// rst_ni clears the parse state and empties the queue; a stalled output only holds back input
// once the queue is nearly full
module s2xv2_delivery_descriptor_parser #(
  parameter int unsigned QueueDepthLog2 = s2dd_pkg::QUEUE_DEPTH_LOG2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       field_code_o,
  output logic [39:0]      field_value_o,
  output logic             end_of_run_o
);

  localparam int unsigned QDepth  = 1 << QueueDepthLog2;
  localparam int unsigned PtrW    = QueueDepthLog2;
  localparam int unsigned CntW    = QueueDepthLog2 + 1;
  localparam int unsigned NumCand = s2dd_pkg::MAX_RESULTS + 1;

  // parse state
  s2dd_pkg::phase_e phase_q, phase_d;
  logic [2:0]       bif_q, bif_d;
  logic [39:0]      accum_q, accum_d;
  logic [3:0]       mode_q, mode_d;
  logic             msf_q, msf_d;
  logic [1:0]       bond_q, bond_d;
  logic             scr_q, scr_d;
  logic             fip_q, fip_d;
  logic             hop_q, hop_d;
  logic [1:0]       bonds_left_q, bonds_left_d;

  // result queue
  s2dd_pkg::result_t queue_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // byte decode
  logic [7:0]  bcd_pair;
  logic [39:0] accum_shift, accum_bcd, accum_new;
  logic [2:0]  bif_inc;
  logic        complete, sf_mode;
  logic [17:0] applies_mask, above_mask, cand_mask, seq_next;
  s2dd_pkg::phase_e phase_next;

  // result candidates in output order: sffi, three field results, end marker
  logic              cand_valid [NumCand];
  s2dd_pkg::field_e  cand_code  [NumCand];
  logic [39:0]       cand_value [NumCand];
  s2dd_pkg::result_t res [s2dd_pkg::MAX_RESULTS];
  logic [2:0]        n_push;

  always_comb begin
    // two bcd digits as one base-100 digit
    bcd_pair    = {1'b0, data_byte_i[7:4], 3'b000} + {3'b000, data_byte_i[7:4], 1'b0}
                + {4'h0, data_byte_i[3:0]};
    accum_shift = {accum_q[31:0], data_byte_i};
    accum_bcd   = (accum_q << 6) + (accum_q << 5) + (accum_q << 2) + {32'h0, bcd_pair};
    accum_new   = (phase_q == s2dd_pkg::PH_FREQ || phase_q == s2dd_pkg::PH_SYMR)
                ? accum_bcd : accum_shift;
    bif_inc     = bif_q + 3'd1;
    complete    = bif_inc >= s2dd_pkg::phase_len(phase_q);
    sf_mode     = (mode_q == 4'd4) || (mode_q == 4'd5);

    // optional fields present in this descriptor
    applies_mask = 18'(s2dd_pkg::PH_RESERVED);
    if (msf_q)
      applies_mask = applies_mask | 18'(s2dd_pkg::PH_ISI);
    if ((mode_q == 4'd1 || mode_q == 4'd2) && scr_q)
      applies_mask = applies_mask | 18'(s2dd_pkg::PH_SCR);
    if (mode_q == 4'd2 || mode_q == 4'd5)
      applies_mask = applies_mask | 18'(s2dd_pkg::PH_TSLICE);
    if (bond_q == 2'd1)
      applies_mask = applies_mask | 18'(s2dd_pkg::PH_NBOND) | 18'(s2dd_pkg::PH_SECID);
    if (sf_mode)
      applies_mask = applies_mask | 18'(s2dd_pkg::PH_SOSF) | 18'(s2dd_pkg::PH_REFIDX)
                   | 18'(s2dd_pkg::PH_PAYIDX) | 18'(s2dd_pkg::PH_PILOT);
    if (sf_mode && hop_q)
      applies_mask = applies_mask | 18'(s2dd_pkg::PH_BHID);

    // lowest present phase above the current one
    above_mask = ~(18'(phase_q) | (18'(phase_q) - 18'd1));
    cand_mask  = applies_mask & above_mask;
    seq_next   = cand_mask & (~cand_mask + 18'd1);

    priority if (18'(phase_q) < 18'(s2dd_pkg::PH_SYMR))
      phase_next = s2dd_pkg::phase_e'(18'(phase_q) << 1);
    else if (phase_q == s2dd_pkg::PH_RESERVED)
      phase_next = s2dd_pkg::PH_RESERVED;
    else if (phase_q == s2dd_pkg::PH_SECID && bonds_left_q != 2'd0)
      phase_next = s2dd_pkg::PH_SECID;
    else
      phase_next = s2dd_pkg::phase_e'(seq_next);

    for (int i = 0; i < NumCand; i++) begin
      cand_valid[i] = 1'b0;
      cand_code[i]  = s2dd_pkg::FC_RESERVED_BYTE;
      cand_value[i] = '0;
    end

    // state update defaults
    phase_d      = phase_q;
    bif_d        = bif_inc;
    accum_d      = accum_new;
    mode_d       = mode_q;
    msf_d        = msf_q;
    bond_d       = bond_q;
    scr_d        = scr_q;
    fip_d        = fip_q;
    hop_d        = hop_q;
    bonds_left_d = bonds_left_q;

    if (phase_q == s2dd_pkg::PH_REFIDX && bif_inc == 3'd1) begin
      fip_d = data_byte_i[7];
      hop_d = data_byte_i[6];
    end
    if (phase_q == s2dd_pkg::PH_PAYIDX && bif_inc == 3'd1 && fip_q) begin
      cand_valid[0] = 1'b1;
      cand_code[0]  = s2dd_pkg::FC_SFFI;
      cand_value[0] = {36'h0, data_byte_i[7:4]};
    end

    if (complete) begin
      cand_valid[1] = 1'b1;
      unique case (phase_q)
        s2dd_pkg::PH_SYSID: begin
          cand_code[1]  = s2dd_pkg::FC_SYSTEM_ID;
          cand_value[1] = {8'h0, accum_new[31:0]};
        end
        s2dd_pkg::PH_MODE: begin
          mode_d        = data_byte_i[7:4];
          msf_d         = data_byte_i[3];
          cand_code[1]  = s2dd_pkg::FC_MODE;
          cand_value[1] = {36'h0, data_byte_i[7:4]};
          cand_valid[2] = 1'b1;
          cand_code[2]  = s2dd_pkg::FC_MULTI_STREAM;
          cand_value[2] = {39'h0, data_byte_i[3]};
          cand_valid[3] = 1'b1;
          cand_code[3]  = s2dd_pkg::FC_ROLL_OFF;
          cand_value[3] = {37'h0, data_byte_i[2:0]};
        end
        s2dd_pkg::PH_BOND: begin
          bond_d        = data_byte_i[3:2];
          cand_code[1]  = s2dd_pkg::FC_NCR_VERSION;
          cand_value[1] = {39'h0, data_byte_i[4]};
          cand_valid[2] = 1'b1;
          cand_code[2]  = s2dd_pkg::FC_CHANNEL_BOND;
          cand_value[2] = {38'h0, data_byte_i[3:2]};
          cand_valid[3] = 1'b1;
          cand_code[3]  = s2dd_pkg::FC_POLARIZATION;
          cand_value[3] = {38'h0, data_byte_i[1:0]};
        end
        s2dd_pkg::PH_PROF: begin
          scr_d         = (mode_q == 4'd1 || mode_q == 4'd2) && data_byte_i[7];
          cand_code[1]  = s2dd_pkg::FC_TS_GS_MODE;
          cand_value[1] = {38'h0, data_byte_i[6:5]};
          cand_valid[2] = 1'b1;
          cand_code[2]  = s2dd_pkg::FC_RX_PROFILES;
          cand_value[2] = {35'h0, data_byte_i[4:0]};
        end
        s2dd_pkg::PH_SAT: begin
          cand_code[1]  = s2dd_pkg::FC_SATELLITE_ID;
          cand_value[1] = {16'h0, accum_new[23:0]};
        end
        s2dd_pkg::PH_FREQ: begin
          // times 10000, wraps at 40 bits
          cand_code[1]  = s2dd_pkg::FC_FREQUENCY;
          cand_value[1] = (accum_new << 13) + (accum_new << 10) + (accum_new << 9)
                        + (accum_new << 8) + (accum_new << 4);
        end
        s2dd_pkg::PH_SYMR: begin
          cand_code[1]  = s2dd_pkg::FC_SYMBOL_RATE;
          cand_value[1] = (accum_new << 6) + (accum_new << 5) + (accum_new << 2);
        end
        s2dd_pkg::PH_ISI: begin
          cand_code[1]  = s2dd_pkg::FC_INPUT_STREAM;
          cand_value[1] = {32'h0, accum_new[7:0]};
        end
        s2dd_pkg::PH_SCR: begin
          cand_code[1]  = s2dd_pkg::FC_SCRAMBLE_IDX;
          cand_value[1] = {22'h0, accum_new[17:0]};
        end
        s2dd_pkg::PH_TSLICE: begin
          cand_code[1]  = s2dd_pkg::FC_TIMESLICE;
          cand_value[1] = {32'h0, accum_new[7:0]};
        end
        s2dd_pkg::PH_NBOND: begin
          bonds_left_d  = {1'b0, data_byte_i[0]};
          cand_code[1]  = s2dd_pkg::FC_BONDS_MINUS1;
          cand_value[1] = {39'h0, data_byte_i[0]};
        end
        s2dd_pkg::PH_SECID: begin
          if (bonds_left_q != 2'd0)
            bonds_left_d = bonds_left_q - 2'd1;
          cand_code[1]  = s2dd_pkg::FC_SECONDARY_ID;
          cand_value[1] = {8'h0, accum_new[31:0]};
        end
        s2dd_pkg::PH_SOSF: begin
          cand_code[1]  = s2dd_pkg::FC_SOSF_WH;
          cand_value[1] = {32'h0, accum_new[7:0]};
        end
        s2dd_pkg::PH_REFIDX: begin
          cand_code[1]  = s2dd_pkg::FC_REF_SCR_IDX;
          cand_value[1] = {20'h0, accum_new[19:0]};
        end
        s2dd_pkg::PH_PAYIDX: begin
          cand_code[1]  = s2dd_pkg::FC_PAY_SCR_IDX;
          cand_value[1] = {20'h0, accum_new[19:0]};
        end
        s2dd_pkg::PH_BHID: begin
          cand_code[1]  = s2dd_pkg::FC_HOP_PLAN_ID;
          cand_value[1] = {8'h0, accum_new[31:0]};
        end
        s2dd_pkg::PH_PILOT: begin
          cand_code[1]  = s2dd_pkg::FC_PILOTS_WH;
          cand_value[1] = {35'h0, data_byte_i[7:3]};
        end
        default: begin
          cand_code[1]  = s2dd_pkg::FC_RESERVED_BYTE;
          cand_value[1] = {32'h0, data_byte_i};
        end
      endcase
      phase_d = phase_next;
      bif_d   = 3'd0;
      accum_d = '0;
    end

    if (last_byte_i) begin
      // end only if the byte left us at a reserved-byte boundary
      cand_valid[4] = 1'b1;
      cand_code[4]  = (phase_d == s2dd_pkg::PH_RESERVED && bif_d == 3'd0)
                    ? s2dd_pkg::FC_END : s2dd_pkg::FC_TRUNCATED;
      phase_d      = s2dd_pkg::PH_SYSID;
      bif_d        = 3'd0;
      accum_d      = '0;
      mode_d       = 4'd0;
      msf_d        = 1'b0;
      bond_d       = 2'd0;
      scr_d        = 1'b0;
      fip_d        = 1'b0;
      hop_d        = 1'b0;
      bonds_left_d = 2'd0;
    end

    // pack candidates into consecutive queue slots
    for (int k = 0; k < s2dd_pkg::MAX_RESULTS; k++)
      res[k] = '0;
    n_push = 3'd0;
    for (int i = 0; i < NumCand; i++) begin
      if (cand_valid[i] && n_push < 3'(s2dd_pkg::MAX_RESULTS)) begin
        res[n_push[1:0]].code  = cand_code[i];
        res[n_push[1:0]].value = cand_value[i];
        n_push = n_push + 3'd1;
      end
    end
    for (int k = 0; k < s2dd_pkg::MAX_RESULTS; k++)
      res[k].eor = (3'(k) == n_push - 3'd1);
    if (!in_fire)
      n_push = 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= s2dd_pkg::PH_SYSID;
      bif_q        <= 3'd0;
      accum_q      <= '0;
      mode_q       <= 4'd0;
      msf_q        <= 1'b0;
      bond_q       <= 2'd0;
      scr_q        <= 1'b0;
      fip_q        <= 1'b0;
      hop_q        <= 1'b0;
      bonds_left_q <= 2'd0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      bif_q        <= bif_d;
      accum_q      <= accum_d;
      mode_q       <= mode_d;
      msf_q        <= msf_d;
      bond_q       <= bond_d;
      scr_q        <= scr_d;
      fip_q        <= fip_d;
      hop_q        <= hop_d;
      bonds_left_q <= bonds_left_d;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (out_fire)
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + CntW'(n_push) - CntW'(out_fire);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < s2dd_pkg::MAX_RESULTS; k++) begin
      if (3'(k) < n_push)
        queue_q[PtrW'(wr_ptr_q + PtrW'(k))] <= res[k];
    end
  end

  assign in_ready_o    = count_q <= CntW'(QDepth - s2dd_pkg::MAX_RESULTS);
  assign out_valid_o   = count_q != '0;
  assign field_code_o  = queue_q[rd_ptr_q].code;
  assign field_value_o = queue_q[rd_ptr_q].value;
  assign end_of_run_o  = queue_q[rd_ptr_q].eor;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QDepth))
    else $error("result queue overfilled");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + CntW'($past(n_push)) - CntW'($past(out_fire)))
    else $error("queue level does not follow pushes and pops");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parse phase lost one-hot coding");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=> (phase_q == s2dd_pkg::PH_SYSID && bif_q == 3'd0))
    else $error("parser did not restart after final byte");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |-> n_push != 3'd0)
    else $error("final byte produced no end result");

  a_bif_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bif_q <= 3'd3)
    else $error("byte counter ran past field length");

endmodule

`default_nettype wire

// File: sim/s2dd_result_checker.sv
`timescale 1ns / 1ps

// watches both channels of the descriptor parser, decodes every accepted byte
// on its own and compares each result transfer with the oldest decoded field
module s2dd_result_checker
  import s2dd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [4:0]  field_code_i,
  input  wire logic [39:0] field_value_i,
  input  wire logic        end_of_run_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam logic [3:0] MODE_SCR       = 4'd1;
  localparam logic [3:0] MODE_SCR_SLICE = 4'd2;
  localparam logic [3:0] MODE_SF        = 4'd4;
  localparam logic [3:0] MODE_SF_SLICE  = 4'd5;
  localparam logic [1:0] BOND_ON        = 2'd1;

  // decoder copy of the parse state
  phase_e      phase_q;
  logic [2:0]  nbytes_q;
  logic [39:0] acc_q;
  logic [3:0]  mode_q;
  logic        multi_q;
  logic [1:0]  bond_q;
  logic        scr_sel_q;
  logic        sffi_sel_q;
  logic        hop_sel_q;
  logic [1:0]  bonds_left_q;

  result_t burst[$];
  result_t expected_fields[$];
  result_t want;
  int      mismatches;

  task automatic clear_parse();
    phase_q      = PH_SYSID;
    nbytes_q     = '0;
    acc_q        = '0;
    mode_q       = '0;
    multi_q      = 1'b0;
    bond_q       = '0;
    scr_sel_q    = 1'b0;
    sffi_sel_q   = 1'b0;
    hop_sel_q    = 1'b0;
    bonds_left_q = '0;
  endtask

  task automatic emit(input field_e code, input logic [39:0] value);
    result_t r;
    if (burst.size() < MAX_RESULTS) begin
      r.code  = code;
      r.value = value;
      r.eor   = 1'b0;
      burst.insert(burst.size(), r);
    end
  endtask

  function automatic logic [2:0] field_bytes(input phase_e p);
    case (p)
      PH_SYSID, PH_FREQ, PH_SYMR, PH_SECID, PH_BHID: return 3'd4;
      PH_SAT, PH_SCR, PH_REFIDX, PH_PAYIDX:          return 3'd3;
      default:                                       return 3'd1;
    endcase
  endfunction

  function automatic logic field_present(input phase_e p);
    case (p)
      PH_ISI:    return multi_q;
      PH_SCR:    return (mode_q == MODE_SCR || mode_q == MODE_SCR_SLICE) && scr_sel_q;
      PH_TSLICE: return mode_q == MODE_SCR_SLICE || mode_q == MODE_SF_SLICE;
      PH_NBOND, PH_SECID: return bond_q == BOND_ON;
      PH_BHID:   return (mode_q == MODE_SF || mode_q == MODE_SF_SLICE) && hop_sel_q;
      PH_SOSF, PH_REFIDX, PH_PAYIDX, PH_PILOT: return mode_q == MODE_SF || mode_q == MODE_SF_SLICE;
      default:   return 1'b1;
    endcase
  endfunction

  // header phases follow in order, optional ones are skipped when absent
  function automatic phase_e following_phase(input phase_e cur);
    phase_e p;
    p = phase_e'(cur << 1);
    if (cur < PH_SYMR) return p;
    while (p != PH_RESERVED && !field_present(p)) p = phase_e'(p << 1);
    return p;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last);
    phase_e      ph;
    logic [39:0] v;
    result_t     tail;
    ph = phase_q;
    burst.delete();
    // bcd fields build the decimal value, all others shift in bytes
    if (ph == PH_FREQ || ph == PH_SYMR)
      acc_q = 40'(({24'd0, acc_q} * 64'd100) + 64'(b[7:4]) * 64'd10 + 64'(b[3:0]));
    else
      acc_q = {acc_q[31:0], b};
    nbytes_q = nbytes_q + 3'd1;
    if (ph == PH_REFIDX && nbytes_q == 3'd1) begin
      sffi_sel_q = b[7];
      hop_sel_q  = b[6];
    end
    if (ph == PH_PAYIDX && nbytes_q == 3'd1 && sffi_sel_q) emit(FC_SFFI, 40'(b[7:4]));
    if (nbytes_q >= field_bytes(ph)) begin
      v = acc_q;
      case (ph)
        PH_SYSID: emit(FC_SYSTEM_ID, 40'(v[31:0]));
        PH_MODE: begin
          mode_q  = b[7:4];
          multi_q = b[3];
          emit(FC_MODE, 40'(b[7:4]));
          emit(FC_MULTI_STREAM, 40'(b[3]));
          emit(FC_ROLL_OFF, 40'(b[2:0]));
        end
        PH_BOND: begin
          bond_q = b[3:2];
          emit(FC_NCR_VERSION, 40'(b[4]));
          emit(FC_CHANNEL_BOND, 40'(b[3:2]));
          emit(FC_POLARIZATION, 40'(b[1:0]));
        end
        PH_PROF: begin
          scr_sel_q = (mode_q == MODE_SCR || mode_q == MODE_SCR_SLICE) && b[7];
          emit(FC_TS_GS_MODE, 40'(b[6:5]));
          emit(FC_RX_PROFILES, 40'(b[4:0]));
        end
        PH_SAT:    emit(FC_SATELLITE_ID, 40'(v[23:0]));
        PH_FREQ:   emit(FC_FREQUENCY, 40'({24'd0, v} * 64'd10000));
        PH_SYMR:   emit(FC_SYMBOL_RATE, 40'({24'd0, v} * 64'd100));
        PH_ISI:    emit(FC_INPUT_STREAM, 40'(v[7:0]));
        PH_SCR:    emit(FC_SCRAMBLE_IDX, 40'(v[17:0]));
        PH_TSLICE: emit(FC_TIMESLICE, 40'(v[7:0]));
        PH_NBOND: begin
          bonds_left_q = {1'b0, b[0]};
          emit(FC_BONDS_MINUS1, 40'(b[0]));
        end
        PH_SECID:  emit(FC_SECONDARY_ID, 40'(v[31:0]));
        PH_SOSF:   emit(FC_SOSF_WH, 40'(v[7:0]));
        PH_REFIDX: emit(FC_REF_SCR_IDX, 40'(v[19:0]));
        PH_PAYIDX: emit(FC_PAY_SCR_IDX, 40'(v[19:0]));
        PH_BHID:   emit(FC_HOP_PLAN_ID, 40'(v[31:0]));
        PH_PILOT:  emit(FC_PILOTS_WH, 40'(b[7:3]));
        default:   emit(FC_RESERVED_BYTE, 40'(b));
      endcase
      acc_q    = '0;
      nbytes_q = '0;
      if (ph == PH_SECID && bonds_left_q != 2'd0) bonds_left_q = bonds_left_q - 2'd1;
      else if (ph != PH_RESERVED) ph = following_phase(ph);
    end
    phase_q = ph;
    if (last) begin
      if (ph == PH_RESERVED && nbytes_q == 3'd0) emit(FC_END, '0);
      else emit(FC_TRUNCATED, '0);
      clear_parse();
    end
    if (burst.size() > 0) begin
      tail = burst.pop_back();
      tail.eor = 1'b1;
      burst.insert(burst.size(), tail);
    end
    foreach (burst[i]) expected_fields.insert(expected_fields.size(), burst[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      expected_fields.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_fields.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, code %0d value %0d eor %0b",
                   $time, field_code_i, field_value_i, end_of_run_i);
        end else begin
          want = expected_fields.pop_front();
          if (field_code_i !== want.code) begin
            mismatches++;
            $display("%0t: field_code expected %0d actual %0d",
                     $time, want.code, field_code_i);
          end
          if (field_value_i !== want.value) begin
            mismatches++;
            $display("%0t: field_value (code %0d) expected %0d actual %0d",
                     $time, want.code, want.value, field_value_i);
          end
          if (end_of_run_i !== want.eor) begin
            mismatches++;
            $display("%0t: end_of_run (code %0d) expected %0b actual %0b",
                     $time, want.code, want.eor, end_of_run_i);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_fields.size();
    end
  end

endmodule

// File: sim/tb_s2xv2_delivery_descriptor_parser.sv
`timescale 1ns / 1ps

module tb_s2xv2_delivery_descriptor_parser;

  localparam logic [3:0] MODE_SCR       = 4'd1;
  localparam logic [3:0] MODE_SCR_SLICE = 4'd2;
  localparam logic [3:0] MODE_SF        = 4'd4;
  localparam logic [3:0] MODE_SF_SLICE  = 4'd5;
  localparam logic [1:0] BOND_ON        = 2'd1;

  localparam int RANDOM_BYTES = 290;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  field_code_o;
  logic [39:0] field_value_o;
  logic        end_of_run_o;

  int   mismatch_count;
  int   fields_pending;
  int   bytes_sent = 0;
  bit   all_sent = 1'b0;
  logic hold_rx;

  logic [7:0] stim_byte[$];
  logic       stim_last[$];

  s2xv2_delivery_descriptor_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_code_o  (field_code_o),
    .field_value_o (field_value_o),
    .end_of_run_o  (end_of_run_o)
  );

  s2dd_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_code_i  (field_code_o),
    .field_value_i (field_value_o),
    .end_of_run_i  (end_of_run_o),
    .fail_count_o  (mismatch_count),
    .pending_o     (fields_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic push_item(input logic [7:0] b, input logic last);
    stim_byte.insert(stim_byte.size(), b);
    stim_last.insert(stim_last.size(), last);
  endtask

  // one descriptor with random content; mostly well formed so that the
  // optional fields of every mode get reached, sometimes cut short or noise
  task automatic gen_descriptor();
    logic [7:0] d[$];
    logic [7:0] b;
    logic [3:0] mode;
    logic [1:0] bond;
    logic       multi;
    logic       scr_sel;
    logic       hop_sel;
    int         cut;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) d.insert(d.size(), 8'($urandom));
    end else begin
      repeat (4) d.insert(d.size(), 8'($urandom));
      mode = ($urandom_range(0, 7) != 0) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(6, 15));
      b = {mode, 4'($urandom)};
      multi = b[3];
      d.insert(d.size(), b);
      b = 8'($urandom);
      if ($urandom_range(0, 1) != 0) b[3:2] = BOND_ON;
      bond = b[3:2];
      d.insert(d.size(), b);
      b = 8'($urandom);
      scr_sel = b[7];
      d.insert(d.size(), b);
      repeat (3) d.insert(d.size(), 8'($urandom));
      // frequency and symbol rate, mostly legal digits
      repeat (8) d.insert(d.size(), ($urandom_range(0, 3) != 0) ?
          {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))} : 8'($urandom));
      if (multi) d.insert(d.size(), 8'($urandom));
      if ((mode == MODE_SCR || mode == MODE_SCR_SLICE) && scr_sel)
        repeat (3) d.insert(d.size(), 8'($urandom));
      if (mode == MODE_SCR_SLICE || mode == MODE_SF_SLICE) d.insert(d.size(), 8'($urandom));
      if (bond == BOND_ON) begin
        b = 8'($urandom);
        d.insert(d.size(), b);
        repeat (b[0] ? 8 : 4) d.insert(d.size(), 8'($urandom));
      end
      if (mode == MODE_SF || mode == MODE_SF_SLICE) begin
        d.insert(d.size(), 8'($urandom));
        b = 8'($urandom);
        hop_sel = b[6];
        d.insert(d.size(), b);
        // rest of the reference index and the payload index
        repeat (5) d.insert(d.size(), 8'($urandom));
        if (hop_sel) repeat (4) d.insert(d.size(), 8'($urandom));
        d.insert(d.size(), 8'($urandom));
      end
      repeat ($urandom_range(0, 3)) d.insert(d.size(), 8'($urandom));
    end
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, d.size()) : d.size();
    for (int i = 0; i < cut; i++) push_item(d[i], i == cut - 1);
  endtask

  // byte sender
  initial begin : byte_source
    int gap;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;

    // a lone last byte: truncated before any field completes
    push_item(8'hFF, 1'b1);
    // header only: max system id, zero satellite id, mode 0, bad bcd frequency that
    // wraps, then one reserved byte closing with the end marker
    repeat (4) push_item(8'hFF, 1'b0);
    push_item(8'h07, 1'b0);
    push_item(8'hF3, 1'b0);
    push_item(8'hFF, 1'b0);
    repeat (3) push_item(8'h00, 1'b0);
    repeat (4) push_item(8'hFF, 1'b0);
    repeat (4) push_item(8'h99, 1'b0);
    push_item(8'h00, 1'b1);
    // cut inside the system id with zero data
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b1);

    while (stim_byte.size() < RANDOM_BYTES) gen_descriptor();

    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < stim_byte.size(); i++) begin
      // a stretch of back-to-back bytes
      gap = (i >= 120 && i < 180) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= stim_byte[i];
      last_byte_i <= stim_last[i];
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      bytes_sent = i + 1;
    end
    in_valid_i <= 1'b0;
    all_sent = 1'b1;
  end

  // long receiver stall while bytes keep coming, so the result queue fills
  initial begin : rx_holdoff
    hold_rx <= 1'b0;
    wait (bytes_sent >= 60);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // result receiver
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = (taken >= 50 && taken < 120) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      while (hold_rx) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : verdict
    wait (all_sent);
    do @(posedge clk_i); while (fields_pending != 0);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && fields_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
